### hdl/aes_pkg.sv
package aes_pkg;

  localparam int unsigned NumRounds = 14;
  localparam int unsigned RkRows    = NumRounds + 1;
  localparam int unsigned RowAw     = $clog2(RkRows);
  localparam int unsigned BlkBytes  = 16;
  localparam int unsigned CntW      = 5;
  localparam int unsigned CfgAw     = 3;

  localparam logic [7:0] GfPoly  = 8'h1b;
  localparam logic [7:0] RconIni = 8'h01;

  localparam logic [CfgAw-1:0] REG_KEY0   = 3'd0;
  localparam logic [CfgAw-1:0] REG_KEY1   = 3'd1;
  localparam logic [CfgAw-1:0] REG_KEY2   = 3'd2;
  localparam logic [CfgAw-1:0] REG_KEY3   = 3'd3;
  localparam logic [CfgAw-1:0] REG_IV_HI  = 3'd4;
  localparam logic [CfgAw-1:0] REG_IV_LO  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_PREP,
    ST_ROUND,
    ST_DONE
  } dec_state_t;

  typedef struct packed {
    logic             en;
    logic [RowAw-1:0] addr;
    logic [127:0]     data;
    logic             last;
  } kexp_wr_t;

  typedef struct packed {
    logic first;
    logic last;
  } round_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? GfPoly : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

### hdl/aes_chan_if.sv
interface aes_cipher_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;
  logic [4:0]  valid_bytes;
  logic        restart;

  modport source(output valid, cipher_high, cipher_low, valid_bytes, restart, input ready);
  modport sink(input valid, cipher_high, cipher_low, valid_bytes, restart, output ready);
endinterface

interface aes_plain_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_high;
  logic [63:0] plain_low;
  logic [4:0]  out_bytes;
  logic        stream_end;

  modport source(output valid, plain_high, plain_low, out_bytes, stream_end, input ready);
  modport sink(input valid, plain_high, plain_low, out_bytes, stream_end, output ready);
endinterface

### hdl/aes_ram.sv
module aes_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/aes_kexp.sv
module aes_kexp (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [255:0]        key,
  output aes_pkg::kexp_wr_t   wr
);
  import aes_pkg::*;

  logic             active;
  logic [RowAw-1:0] cnt;
  logic [127:0]     prev2;
  logic [127:0]     prev1;
  logic [7:0]       rc;
  logic [31:0]      t;
  logic [31:0]      w0, w1, w2, w3;
  logic [127:0]     new_row;
  logic             is_last;

  always_comb begin
    if (!cnt[0]) begin
      t = sub_word({prev1[23:0], prev1[31:24]}) ^ {rc, 24'h000000};
    end else begin
      t = sub_word(prev1[31:0]);
    end
    w0 = prev2[127:96] ^ t;
    w1 = prev2[95:64] ^ w0;
    w2 = prev2[63:32] ^ w1;
    w3 = prev2[31:0] ^ w2;
    new_row = {w0, w1, w2, w3};
    is_last = (cnt == RowAw'(RkRows - 1));
  end

  always_comb begin
    wr.en   = active;
    wr.addr = cnt;
    wr.last = active && is_last;
    if (cnt == RowAw'(0)) begin
      wr.data = prev2;
    end else if (cnt == RowAw'(1)) begin
      wr.data = prev1;
    end else begin
      wr.data = new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (start) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (active) begin
      cnt <= cnt + RowAw'(1);
      if (is_last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prev2 <= key[255:128];
      prev1 <= key[127:0];
      rc    <= RconIni;
    end else if (active && cnt >= RowAw'(2)) begin
      prev2 <= prev1;
      prev1 <= new_row;
      if (!cnt[0]) begin
        rc <= gf_double(rc);
      end
    end
  end

endmodule

### hdl/aes_round.sv
module aes_round (
  input  aes_pkg::round_ctl_t ctl,
  input  logic [127:0]        state_in,
  input  logic [127:0]        round_key,
  output logic [127:0]        state_out
);
  import aes_pkg::*;

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];
  logic [7:0] a0, a1, a2, a3, x;
  logic [127:0] mixed;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = SBOX[state_in[127 - 8 * i -: 8]];
    end
    for (int i = 0; i < 16; i++) begin
      t[i] = s[(i + 4 * (i % 4)) % 16];
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4 * c];
      a1 = t[4 * c + 1];
      a2 = t[4 * c + 2];
      a3 = t[4 * c + 3];
      x  = a0 ^ a1 ^ a2 ^ a3;
      if (ctl.last) begin
        m[4 * c]     = a0;
        m[4 * c + 1] = a1;
        m[4 * c + 2] = a2;
        m[4 * c + 3] = a3;
      end else begin
        m[4 * c]     = a0 ^ x ^ gf_double(a0 ^ a1);
        m[4 * c + 1] = a1 ^ x ^ gf_double(a1 ^ a2);
        m[4 * c + 2] = a2 ^ x ^ gf_double(a2 ^ a3);
        m[4 * c + 3] = a3 ^ x ^ gf_double(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      mixed[127 - 8 * i -: 8] = m[i];
    end
    if (ctl.first) begin
      state_out = state_in ^ round_key;
    end else begin
      state_out = mixed ^ round_key;
    end
  end

endmodule

### hdl/aes256_cfb_decryptor.sv
// Each accepted request is run by one shared AES round unit that does the key addition and
// fourteen rounds in turn, after a key expansion when restart is set.
// A restart first expands the key at one 128-bit round key row per cycle into a 15-row RAM.
// A new request is taken once the result is registered; the result waits while the output is busy.
// Reset is synchronous: key, IV and feedback clear to zero.
module aes256_cfb_decryptor (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_en,
  input  logic [aes_pkg::CfgAw-1:0] cfg_addr,
  input  logic [63:0]               cfg_data,
  aes_cipher_if.sink                cipher,
  aes_plain_if.source               plain
);
  import aes_pkg::*;

  dec_state_t       state, state_next;
  logic [63:0]      key_reg [4];
  logic [63:0]      iv_high;
  logic [63:0]      iv_low;
  logic [127:0]     fb;
  logic [127:0]     ct;
  logic [CntW-1:0]  nbytes;
  logic [127:0]     st;
  logic [RowAw-1:0] rnd;
  logic [RowAw-1:0] raddr;
  logic [127:0]     rk_row;
  logic [127:0]     round_out;
  logic [127:0]     byte_mask;
  logic [CntW-1:0]  n_in;
  logic             accept;
  logic             kexp_start;
  logic             out_free;
  kexp_wr_t         kwr;
  round_ctl_t       rctl;

  assign accept     = cipher.valid && cipher.ready;
  assign kexp_start = accept && cipher.restart;
  assign out_free   = !plain.valid || plain.ready;

  always_comb begin
    if (cipher.valid_bytes == CntW'(0) || cipher.valid_bytes > CntW'(BlkBytes)) begin
      n_in = CntW'(BlkBytes);
    end else begin
      n_in = cipher.valid_bytes;
    end
  end

  aes_kexp u_kexp (
    .clk   (clk),
    .rst   (rst),
    .start (kexp_start),
    .key   ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
    .wr    (kwr)
  );

  aes_ram #(
    .WIDTH (128),
    .DEPTH (RkRows)
  ) u_rk_ram (
    .clk   (clk),
    .we    (kwr.en),
    .waddr (kwr.addr),
    .wdata (kwr.data),
    .raddr (raddr),
    .rdata (rk_row)
  );

  assign rctl.first = (rnd == RowAw'(0));
  assign rctl.last  = (rnd == RowAw'(NumRounds));

  aes_round u_round (
    .ctl       (rctl),
    .state_in  (rctl.first ? fb : st),
    .round_key (rk_row),
    .state_out (round_out)
  );

  always_comb begin
    for (int i = 0; i < BlkBytes; i++) begin
      byte_mask[127 - 8 * i -: 8] = (CntW'(i) < nbytes) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    state_next   = state;
    cipher.ready = 1'b0;
    raddr        = '0;
    unique case (state)
      ST_IDLE: begin
        cipher.ready = 1'b1;
        if (cipher.valid) begin
          state_next = cipher.restart ? ST_EXPAND : ST_PREP;
        end
      end
      ST_EXPAND: begin
        if (kwr.last) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (rctl.last) begin
          state_next = ST_DONE;
        end else begin
          raddr = rnd + RowAw'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_reg[0] <= '0;
      key_reg[1] <= '0;
      key_reg[2] <= '0;
      key_reg[3] <= '0;
      iv_high    <= '0;
      iv_low     <= '0;
    end else if (cfg_en) begin
      unique case (cfg_addr)
        REG_KEY0:  key_reg[0] <= cfg_data;
        REG_KEY1:  key_reg[1] <= cfg_data;
        REG_KEY2:  key_reg[2] <= cfg_data;
        REG_KEY3:  key_reg[3] <= cfg_data;
        REG_IV_HI: iv_high    <= cfg_data;
        REG_IV_LO: iv_low     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fb <= '0;
    end else if (kexp_start) begin
      fb <= {iv_high, iv_low};
    end else if (state == ST_DONE && out_free) begin
      fb <= (ct & byte_mask) | (fb & ~byte_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ct     <= {cipher.cipher_high, cipher.cipher_low};
      nbytes <= n_in;
    end
    if (state == ST_PREP) begin
      rnd <= '0;
    end else if (state == ST_ROUND) begin
      st <= round_out;
      if (!rctl.last) begin
        rnd <= rnd + RowAw'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plain.valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      plain.valid <= 1'b1;
    end else if (plain.ready) begin
      plain.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      {plain.plain_high, plain.plain_low} <= (ct ^ st) & byte_mask;
      plain.out_bytes  <= nbytes;
      plain.stream_end <= (nbytes < CntW'(BlkBytes));
    end
  end

endmodule
